@@ sv/assert_macros.svh @@
// Assertion helper macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled during reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion, always checked.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/lzd_pkg.sv @@
// ---------------------------------------------------------------------------
// lzd_pkg
// Shared types and constants of the LZ back-reference stream decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package lzd_pkg;

    localparam logic [23:0] MAGIC_HEAD = 24'h59617A;
    localparam logic [7:0]  MAGIC_TAIL = 8'h30;
    localparam logic [8:0]  LONG_BIAS  = 9'h012;
    localparam logic [4:0]  SHORT_BIAS = 5'd2;

    // Command from the parser to the copy engine.
    typedef struct packed {
        logic        is_ref;    // 0: literal, 1: back-reference run
        logic        is_err;    // bad reference: emit error result
        logic [7:0]  lit;
        logic [11:0] dist_m1;
        logic [8:0]  len;
        logic [32:0] end_count; // produced count after this command
        logic [31:0] size;      // declared stream size
        logic        new_stream;
    } cmd_t;

endpackage

`default_nettype wire

@@ sv/lzd_stream_if.sv @@
// ---------------------------------------------------------------------------
// lzd_stream_if
// Valid/ready channel carrying a payload of parameterized width.
// ---------------------------------------------------------------------------
`default_nettype none

interface lzd_stream_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/lzd_out_if.sv @@
// ---------------------------------------------------------------------------
// lzd_out_if
// Result channel: packed bytes plus status flags.
// ---------------------------------------------------------------------------
`default_nettype none

interface lzd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        run_last;
    logic        stream_done;
    logic        ref_error;

    modport source (output valid, output out_bytes, output byte_count, output run_last,
                    output stream_done, output ref_error, input ready);
    modport sink   (input valid, input out_bytes, input byte_count, input run_last,
                    input stream_done, input ref_error, output ready);
endinterface

`default_nettype wire

@@ sv/lz_backref_stream_decoder_unit.sv @@
// ---------------------------------------------------------------------------
// lz_backref_stream_decoder_unit
// Streaming LZ back-reference decoder with header search and packed output.
// ---------------------------------------------------------------------------
//   channel   dir  payload                                         transfer
//   in_ch     in   in_byte[7:0]                                    one container byte
//   out_ch    out  out_bytes, byte_count, run_last, stream_done,   one packed result
//                  ref_error
//
// The parser handles header, code and literal bytes itself, one byte at a time.
// In the copy engine each byte of a back-reference run is copied by a registered
// history read and a write back held while a result waits; that loop sets the rate.
// A two-entry command queue decouples parser and engine; input stalls when it fills.
// Reset is asynchronous; the history memory is not cleared.
// After a bad reference the block emits one error result and accepts no more input.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lz_backref_stream_decoder_unit #(
    parameter int WINDOW_DEPTH = 4096,
    parameter int OUT_LANES    = 8
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lzd_stream_if.sink in_ch,
    lzd_out_if.source  out_ch
);
    import lzd_pkg::*;

    // parser -> queue
    logic pq_valid, pq_ready;
    cmd_t pq_cmd;
    // queue -> engine
    logic qe_valid, qe_ready;
    cmd_t qe_cmd;

    // Front end: classifies bytes, tracks header and flag state.
    lzd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_byte   (in_ch.data[7:0]),
        .cmd_valid (pq_valid),
        .cmd_ready (pq_ready),
        .cmd       (pq_cmd)
    );

    lzd_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (pq_valid),
        .wr_ready (pq_ready),
        .wr_cmd   (pq_cmd),
        .rd_valid (qe_valid),
        .rd_ready (qe_ready),
        .rd_cmd   (qe_cmd)
    );

    // Back end: history window and output packing.
    lzd_copy_engine #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .OUT_LANES    (OUT_LANES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (qe_valid),
        .cmd_ready (qe_ready),
        .cmd       (qe_cmd),
        .res       (out_ch)
    );

    `ASSERT_RST(a_err_last, clk, rst_n,
                (out_ch.valid && out_ch.ref_error) |-> out_ch.run_last,
                "error result not marked last")
    `ASSERT_RST(a_done_last, clk, rst_n,
                (out_ch.valid && out_ch.stream_done) |-> out_ch.run_last,
                "stream end not on last result")

endmodule

`default_nettype wire

@@ sv/lzd_parser.sv @@
// ---------------------------------------------------------------------------
// lzd_parser
// Front end: header search, code-byte flags, reference decode.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lzd_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    in_byte,
    output logic               cmd_valid,
    input  wire logic          cmd_ready,
    output lzd_pkg::cmd_t      cmd
);
    import lzd_pkg::*;

    typedef enum logic [6:0] {
        PH_SEARCH   = 7'b0000001,
        PH_SIZE     = 7'b0000010,
        PH_RESERVED = 7'b0000100,
        PH_CODE     = 7'b0001000,
        PH_FLAG     = 7'b0010000,
        PH_REF2     = 7'b0100000,
        PH_REF3     = 7'b1000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [23:0] magic_reg, magic_next;
    logic [31:0] size_reg, size_next;
    logic [3:0]  hcnt_reg, hcnt_next;
    logic [32:0] prod_reg, prod_next;
    logic [7:0]  code_reg, code_next;
    logic [3:0]  left_reg, left_next;
    logic [7:0]  first_reg, first_next;
    logic [7:0]  second_reg, second_next;
    logic        halted_reg, halted_next;
    logic        newstr_reg, newstr_next;

    logic        fire;
    logic [8:0]  run_len;
    logic [32:0] after;
    logic        emit;

    assign in_ready = !halted_reg && (cmd_ready || !emit);
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        phase_next  = phase_reg;
        magic_next  = magic_reg;
        size_next   = size_reg;
        hcnt_next   = hcnt_reg;
        prod_next   = prod_reg;
        code_next   = code_reg;
        left_next   = left_reg;
        first_next  = first_reg;
        second_next = second_reg;
        halted_next = halted_reg;
        newstr_next = newstr_reg;
        emit        = 1'b0;
        run_len     = 9'd0;
        cmd         = '0;
        cmd.size    = size_reg;
        cmd.new_stream = newstr_reg;
        after       = prod_reg;
        unique case (phase_reg)
            PH_SEARCH:
            begin
                if (magic_reg == MAGIC_HEAD && in_byte == MAGIC_TAIL)
                begin
                    phase_next = PH_SIZE;
                    hcnt_next  = '0;
                    size_next  = '0;
                    magic_next = '0;
                end
                else
                begin
                    magic_next = {magic_reg[15:0], in_byte};
                end
            end
            PH_SIZE:
            begin
                size_next = {size_reg[23:0], in_byte};
                if (hcnt_reg == 4'd3)
                begin
                    hcnt_next  = '0;
                    phase_next = PH_RESERVED;
                end
                else
                begin
                    hcnt_next = hcnt_reg + 4'd1;
                end
            end
            PH_RESERVED:
            begin
                if (hcnt_reg == 4'd7)
                begin
                    hcnt_next   = '0;
                    prod_next   = '0;
                    left_next   = '0;
                    code_next   = '0;
                    magic_next  = '0;
                    newstr_next = 1'b1;
                    phase_next  = (size_reg == '0) ? PH_SEARCH : PH_CODE;
                end
                else
                begin
                    hcnt_next = hcnt_reg + 4'd1;
                end
            end
            PH_CODE:
            begin
                code_next  = in_byte;
                left_next  = 4'd8;
                phase_next = PH_FLAG;
            end
            PH_FLAG:
            begin
                if (code_reg[7])
                begin
                    emit    = 1'b1;
                    cmd.lit = in_byte;
                    run_len = 9'd1;
                end
                else
                begin
                    first_next = in_byte;
                    phase_next = PH_REF2;
                end
            end
            PH_REF2:
            begin
                second_next = in_byte;
                if (prod_reg < {20'd0, 1'b0, first_reg[3:0], in_byte} + 33'd1)
                begin
                    emit        = 1'b1;
                    cmd.is_err  = 1'b1;
                    halted_next = 1'b1;
                end
                else if (first_reg[7:4] != 4'd0)
                begin
                    emit    = 1'b1;
                    cmd.is_ref = 1'b1;
                    run_len = {5'd0, first_reg[7:4]} + {4'd0, SHORT_BIAS};
                    cmd.dist_m1 = {first_reg[3:0], in_byte};
                end
                else
                begin
                    phase_next = PH_REF3;
                end
            end
            PH_REF3:
            begin
                emit    = 1'b1;
                cmd.is_ref = 1'b1;
                run_len = {1'b0, in_byte} + LONG_BIAS;
                cmd.dist_m1 = {first_reg[3:0], second_reg};
            end
            default:
            begin
                phase_next = PH_SEARCH;
                magic_next = '0;
            end
        endcase
        cmd.len = run_len;
        after   = prod_reg + {24'd0, run_len};
        cmd.end_count = after;
        if (emit && !cmd.is_err)
        begin
            prod_next   = after;
            newstr_next = 1'b0;
            code_next   = {code_reg[6:0], 1'b0};
            left_next   = (left_reg != 4'd0) ? left_reg - 4'd1 : 4'd0;
            if (after >= {1'b0, size_reg})
            begin
                phase_next = PH_SEARCH;
                magic_next = '0;
            end
            else if (left_next == 4'd0)
            begin
                phase_next = PH_CODE;
            end
            else
            begin
                phase_next = PH_FLAG;
            end
        end
        if (emit && cmd.is_err)
        begin
            newstr_next = newstr_reg;
        end
    end

    assign cmd_valid = fire && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SEARCH;
            magic_reg  <= '0;
            size_reg   <= '0;
            hcnt_reg   <= '0;
            prod_reg   <= '0;
            code_reg   <= '0;
            left_reg   <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            halted_reg <= 1'b0;
            newstr_reg <= 1'b1;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            magic_reg  <= magic_next;
            size_reg   <= size_next;
            hcnt_reg   <= hcnt_next;
            prod_reg   <= prod_next;
            code_reg   <= code_next;
            left_reg   <= left_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            halted_reg <= halted_next;
            newstr_reg <= newstr_next;
        end
    end

    `ASSERT_RST(a_halt_sticky, clk, rst_n, halted_reg |=> halted_reg,
                "parser left halt without reset")
    `ASSERT_RST(a_no_fire_halted, clk, rst_n, halted_reg |-> !cmd_valid,
                "command issued while halted")
    `ASSERT_RST(a_hdr_count, clk, rst_n, (phase_reg == PH_SIZE) |-> (hcnt_reg < 4'd4),
                "size header count out of range")

endmodule

`default_nettype wire

@@ sv/lzd_cmd_fifo.sv @@
// ---------------------------------------------------------------------------
// lzd_cmd_fifo
// Short command queue between parser and copy engine.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lzd_cmd_fifo (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_valid,
    output logic             wr_ready,
    input  wire lzd_pkg::cmd_t wr_cmd,
    output logic             rd_valid,
    input  wire logic        rd_ready,
    output lzd_pkg::cmd_t    rd_cmd
);
    import lzd_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_cmd   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_valid && wr_ready)
        begin
            mem_reg[wp_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_valid && wr_ready)
            begin
                wp_reg <= !wp_reg;
            end
            if (rd_valid && rd_ready)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
        end
    end

    `ASSERT_RST(a_no_overflow, clk, rst_n, cnt_reg <= 2'd2, "command queue count out of range")

endmodule

`default_nettype wire

@@ sv/lzd_copy_engine.sv @@
// ---------------------------------------------------------------------------
// lzd_copy_engine
// Back end: history window, run copy and result packing.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lzd_copy_engine #(
    parameter int WINDOW_DEPTH = 4096,
    parameter int OUT_LANES    = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire lzd_pkg::cmd_t cmd,
    lzd_out_if.source          res
);
    import lzd_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int LW = $clog2(OUT_LANES + 1);

    logic [7:0]    hist_mem [WINDOW_DEPTH];
    logic [AW-1:0] wptr_reg;
    logic [AW-1:0] rptr_reg;
    logic [7:0]    rdata_reg;
    logic          busy_reg;
    logic          rd_pend_reg;
    logic [8:0]    remain_reg;
    logic [LW-1:0] lane_reg;
    logic [63:0]   acc_reg;
    logic          done_reg;

    logic          rv_reg;
    logic [63:0]   rbytes_reg;
    logic [3:0]    rcnt_reg;
    logic          rlast_reg, rdone_reg, rerr_reg;

    logic          out_free;
    logic          take;
    logic [63:0]   acc_new;
    logic          flush;
    logic [AW-1:0] dist_ext;
    logic          res_load;

    assign out_free  = !rv_reg || res.ready;
    assign cmd_ready = !busy_reg && out_free;
    assign take      = cmd_valid && cmd_ready;
    assign dist_ext  = AW'(cmd.dist_m1) + AW'(1);

    assign acc_new = acc_reg | (64'(rdata_reg) << {lane_reg, 3'b000});
    assign flush   = (lane_reg == LW'(OUT_LANES - 1)) || (remain_reg == 9'd1);

    // result register loads on a literal, an error or a full/final pack
    assign res_load = (take && !cmd.is_ref) ||
                      (busy_reg && rd_pend_reg && out_free && flush);

    always_ff @(posedge clk)
    begin
        hist_mem_wr: if (take && !cmd.is_ref && !cmd.is_err)
        begin
            hist_mem[cmd.new_stream ? '0 : wptr_reg] <= cmd.lit;
        end
        else if (busy_reg && rd_pend_reg && out_free)
        begin
            hist_mem[wptr_reg] <= rdata_reg;
        end
        rdata_reg <= hist_mem[rptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg    <= '0;
            rptr_reg    <= '0;
            busy_reg    <= 1'b0;
            rd_pend_reg <= 1'b0;
            remain_reg  <= '0;
            lane_reg    <= '0;
            acc_reg     <= '0;
            done_reg    <= 1'b0;
            rv_reg      <= 1'b0;
            rbytes_reg  <= '0;
            rcnt_reg    <= '0;
            rlast_reg   <= 1'b0;
            rdone_reg   <= 1'b0;
            rerr_reg    <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                rv_reg <= 1'b1;
            end
            else if (rv_reg && res.ready)
            begin
                rv_reg <= 1'b0;
            end
            if (take)
            begin
                if (cmd.is_err)
                begin
                    rbytes_reg <= '0;
                    rcnt_reg   <= '0;
                    rlast_reg  <= 1'b1;
                    rdone_reg  <= 1'b0;
                    rerr_reg   <= 1'b1;
                end
                else if (!cmd.is_ref)
                begin
                    wptr_reg   <= (cmd.new_stream ? '0 : wptr_reg) + AW'(1);
                    rbytes_reg <= {56'd0, cmd.lit};
                    rcnt_reg   <= 4'd1;
                    rlast_reg  <= 1'b1;
                    rdone_reg  <= cmd.end_count >= {1'b0, cmd.size};
                    rerr_reg   <= 1'b0;
                end
                else
                begin
                    busy_reg    <= 1'b1;
                    rd_pend_reg <= 1'b0;
                    rptr_reg    <= wptr_reg - dist_ext;
                    remain_reg  <= cmd.len;
                    lane_reg    <= '0;
                    acc_reg     <= '0;
                    done_reg    <= cmd.end_count >= {1'b0, cmd.size};
                end
            end
            else if (busy_reg)
            begin
                if (!rd_pend_reg)
                begin
                    // rdata_reg is loaded from rptr_reg here; the write back waits for it
                    rd_pend_reg <= 1'b1;
                end
                else if (out_free)
                begin
                    // write back the registered byte, pack it and step both pointers
                    wptr_reg    <= wptr_reg + AW'(1);
                    rptr_reg    <= rptr_reg + AW'(1);
                    rd_pend_reg <= 1'b0;
                    remain_reg  <= remain_reg - 9'd1;
                    if (flush)
                    begin
                        rbytes_reg <= acc_new;
                        rcnt_reg   <= 4'(lane_reg) + 4'd1;
                        rlast_reg  <= remain_reg == 9'd1;
                        rdone_reg  <= (remain_reg == 9'd1) && done_reg;
                        rerr_reg   <= 1'b0;
                        acc_reg    <= '0;
                        lane_reg   <= '0;
                        if (remain_reg == 9'd1)
                        begin
                            busy_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        acc_reg  <= acc_new;
                        lane_reg <= lane_reg + LW'(1);
                    end
                end
            end
        end
    end

    assign res.valid       = rv_reg;
    assign res.out_bytes   = rbytes_reg;
    assign res.byte_count  = rcnt_reg;
    assign res.run_last    = rlast_reg;
    assign res.stream_done = rdone_reg;
    assign res.ref_error   = rerr_reg;

    `ASSERT_RST(a_err_empty, clk, rst_n, (rv_reg && rerr_reg) |-> (rcnt_reg == 4'd0),
                "error result carries bytes")
    `ASSERT_RST(a_busy_len, clk, rst_n, busy_reg |-> (remain_reg != 9'd0),
                "copy active with no bytes left")
    `ASSERT_RST(a_lane_range, clk, rst_n, lane_reg < LW'(OUT_LANES),
                "pack lane out of range")

endmodule

`default_nettype wire

@@ dv/lz_backref_stream_decoder_unit_chk.sv @@
// ---------------------------------------------------------------------------
// lz_backref_stream_decoder_unit_chk
// Watches both channels, predicts decoded results and compares in order.
// ---------------------------------------------------------------------------
`default_nettype none

module lz_backref_stream_decoder_unit_chk (
    input  wire logic clk,
    input  wire logic rst_n,
    lzd_stream_if     in_ch,
    lzd_out_if        out_ch,
    output int        fail_count,
    output int        pending,
    output int        result_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import lzd_pkg::*;

    typedef enum logic [2:0] {
        P_SEARCH, P_SIZE, P_RSVD, P_CODE, P_FLAG, P_REF2, P_REF3
    } parse_e;

    typedef struct {
        logic [63:0] bytes;
        logic [3:0]  cnt;
        logic        last;
        logic        done;
        logic        err;
    } decoded_t;

    decoded_t    decoded_q[$];
    parse_e      phase;
    logic [23:0] window;
    logic [31:0] size;
    logic [3:0]  hdr_cnt;
    logic [32:0] produced;
    logic [7:0]  flags;
    logic [3:0]  flags_left;
    logic [7:0]  ref_hi;
    logic [7:0]  ref_lo;
    logic [7:0]  hist [4096];
    logic [11:0] hist_ptr;
    logic        halted;

    initial
    begin
        phase = P_SEARCH; window = '0; size = '0; hdr_cnt = '0; produced = '0;
        flags = '0; flags_left = '0; ref_hi = '0; ref_lo = '0;
        hist_ptr = '0; halted = 1'b0;
        fail_count = 0; pending = 0; result_count = 0;
    end

    function automatic void push_decoded(logic [63:0] bytes, logic [3:0] cnt,
                                         logic last, logic done, logic err);
        decoded_t d;
        d.bytes = bytes; d.cnt = cnt; d.last = last; d.done = done; d.err = err;
        decoded_q = {decoded_q, d};
    endfunction

    function automatic void store_byte(logic [7:0] b);
        hist[hist_ptr] = b;
        hist_ptr = hist_ptr + 12'd1;
        produced = produced + 33'd1;
    endfunction

    // copy from history, may overlap bytes being written (distance < length)
    function automatic void copy_run(logic [12:0] ref_dist, int len);
        logic [63:0] acc;
        int          lane;
        logic [7:0]  b;
        logic        last;
        acc = '0;
        lane = 0;
        for (int i = 0; i < len; i++)
        begin
            b = hist[hist_ptr - ref_dist[11:0]];
            store_byte(b);
            acc |= 64'(b) << (8 * lane);
            lane++;
            if (lane == 8 || i + 1 == len)
            begin
                last = (i + 1 == len);
                push_decoded(acc, 4'(lane), last, last && produced >= {1'b0, size}, 1'b0);
                acc = '0;
                lane = 0;
            end
        end
    endfunction

    function automatic void end_element();
        flags = flags << 1;
        if (flags_left != 0)
            flags_left--;
        if (produced >= {1'b0, size})
        begin
            phase = P_SEARCH;
            window = '0;
        end
        else if (flags_left == 0)
            phase = P_CODE;
        else
            phase = P_FLAG;
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        logic [12:0] ref_dist;
        if (halted)
            return;
        case (phase)
            P_SEARCH:
            begin
                if (window == MAGIC_HEAD && b == MAGIC_TAIL)
                begin
                    phase = P_SIZE; hdr_cnt = '0; size = '0; window = '0;
                end
                else
                    window = {window[15:0], b};
            end
            P_SIZE:
            begin
                size = {size[23:0], b};
                hdr_cnt++;
                if (hdr_cnt == 4)
                begin
                    hdr_cnt = '0;
                    phase = P_RSVD;
                end
            end
            P_RSVD:
            begin
                hdr_cnt++;
                if (hdr_cnt == 8)
                begin
                    hdr_cnt = '0; produced = '0; hist_ptr = '0;
                    flags_left = '0; flags = '0; window = '0;
                    phase = (size == 0) ? P_SEARCH : P_CODE;
                end
            end
            P_CODE:
            begin
                flags = b;
                flags_left = 4'd8;
                phase = P_FLAG;
            end
            P_FLAG:
            begin
                if (flags[7])
                begin
                    store_byte(b);
                    push_decoded(64'(b), 4'd1, 1'b1, produced >= {1'b0, size}, 1'b0);
                    end_element();
                end
                else
                begin
                    ref_hi = b;
                    phase = P_REF2;
                end
            end
            P_REF2:
            begin
                ref_lo = b;
                ref_dist = {1'b0, ref_hi[3:0], ref_lo} + 13'd1;
                if (produced < 33'(ref_dist))
                begin
                    push_decoded('0, 4'd0, 1'b1, 1'b0, 1'b1);
                    halted = 1'b1;
                end
                else if (ref_hi[7:4] != 0)
                begin
                    copy_run(ref_dist, int'(ref_hi[7:4]) + int'(SHORT_BIAS));
                    end_element();
                end
                else
                    phase = P_REF3;
            end
            P_REF3:
            begin
                ref_dist = {1'b0, ref_hi[3:0], ref_lo} + 13'd1;
                copy_run(ref_dist, int'(b) + int'(LONG_BIAS));
                end_element();
            end
            default:
            begin
                phase = P_SEARCH;
                window = '0;
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        decoded_t exp_d;
        if (rst_n && in_ch.valid && in_ch.ready)
            decode_byte(in_ch.data);
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            result_count++;
            if (decoded_q.size() == 0)
            begin
                $error("unexpected result: out_bytes %h byte_count %0d",
                       out_ch.out_bytes, out_ch.byte_count);
                fail_count++;
            end
            else
            begin
                exp_d = decoded_q.pop_front();
                if (out_ch.out_bytes !== exp_d.bytes)
                begin
                    $error("out_bytes: expected %h, got %h", exp_d.bytes, out_ch.out_bytes);
                    fail_count++;
                end
                if (out_ch.byte_count !== exp_d.cnt)
                begin
                    $error("byte_count: expected %0d, got %0d", exp_d.cnt, out_ch.byte_count);
                    fail_count++;
                end
                if (out_ch.run_last !== exp_d.last)
                begin
                    $error("run_last: expected %b, got %b", exp_d.last, out_ch.run_last);
                    fail_count++;
                end
                if (out_ch.stream_done !== exp_d.done)
                begin
                    $error("stream_done: expected %b, got %b", exp_d.done, out_ch.stream_done);
                    fail_count++;
                end
                if (out_ch.ref_error !== exp_d.err)
                begin
                    $error("ref_error: expected %b, got %b", exp_d.err, out_ch.ref_error);
                    fail_count++;
                end
            end
        end
        pending = decoded_q.size();
    end

endmodule

`default_nettype wire

@@ dv/lz_backref_stream_decoder_unit_tb.sv @@
// ---------------------------------------------------------------------------
// lz_backref_stream_decoder_unit_tb
// Feeds container streams (magic, size, reserved bytes, coded body) through
// the decoder with random idling on both sides; a side checker predicts and
// compares every result. Ends with a bad reference, which halts the block.
// ---------------------------------------------------------------------------
`default_nettype none

module lz_backref_stream_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lzd_pkg::*;

    localparam int WDOG_LIMIT  = 5000;  // idle cycles; kept above the long hold-off
    localparam int RAND_BYTES  = 140;
    localparam int HOLD_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lzd_stream_if #(.W(8)) in_ch ();
    lzd_out_if             out_ch ();

    int fail_count;
    int pending;
    int result_count;

    logic [7:0] stim_q[$];
    int         sent_bytes = 0;
    int         stream_cnt = 0;
    bit         no_gaps = 1'b0;  // burst stretches: no sender idling, receiver ready outside the hold-off

    always #6 clk = ~clk;

    lz_backref_stream_decoder_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    lz_backref_stream_decoder_unit_chk u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ---- receiver: random back-pressure plus one long hold-off ----
    initial
    begin
        int hold;
        int seen;
        bit held;
        hold = 0;
        seen = 0;
        held = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                seen++;
            // once enough results have passed, stop taking them while input keeps coming
            if (!held && seen >= 40)
            begin
                held = 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                out_ch.ready <= 1'b0;
            end
            else if (no_gaps)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 99) < 70);
        end
    end

    // ---- watchdog: cycles without any transfer ----
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle = 0;
            else
                idle++;
            if (idle >= WDOG_LIMIT)
            begin
                $display("timeout after %0d idle cycles", idle);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Sender: valid stays high across back-to-back transfers; it is only
    // lowered when a gap actually follows.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sent_bytes++;
    endtask

    task automatic flush_stim();
        while (stim_q.size() > 0)
            send_byte(stim_q.pop_front());
    endtask

    // called right at the edge of the last transfer, so valid drops at once
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic void queue_byte(logic [7:0] b);
        stim_q = {stim_q, b};
    endfunction

    function automatic void push_header(logic [31:0] sz);
        queue_byte(MAGIC_HEAD[23:16]);
        queue_byte(MAGIC_HEAD[15:8]);
        queue_byte(MAGIC_HEAD[7:0]);
        queue_byte(MAGIC_TAIL);
        for (int i = 3; i >= 0; i--)
            queue_byte(sz[8*i +: 8]);
        for (int i = 0; i < 8; i++)
            queue_byte(8'($urandom_range(0, 255)));
    endfunction

    // Junk between streams; never the magic's last byte so no stray header.
    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == MAGIC_TAIL) ? 8'h31 : b;
    endfunction

    // Well-formed stream with random body; references always stay in range.
    function automatic void push_stream(logic [31:0] sz);
        int         produced;
        int         code_pos;
        logic [7:0] code;
        int         back_dist;
        int         len;
        produced = 0;
        push_header(sz);
        while (produced < sz)
        begin
            code_pos = stim_q.size();
            queue_byte(8'h00);
            code = 8'($urandom_range(0, 255));
            for (int f = 7; f >= 0; f--)
            begin
                if (produced >= sz)
                    break;  // remaining flags dropped by the decoder
                if (produced == 0)
                    code[f] = 1'b1;
                if (code[f])
                begin
                    queue_byte(8'($urandom_range(0, 255)));
                    produced++;
                end
                else
                begin
                    back_dist = $urandom_range(1, (produced < 4096) ? produced : 4096);
                    if ($urandom_range(0, 99) < 75)
                    begin
                        len = $urandom_range(3, 17);
                        queue_byte({4'(len - 2), 4'((back_dist - 1) >> 8)});
                        queue_byte(8'(back_dist - 1));
                    end
                    else
                    begin
                        len = ($urandom_range(0, 99) < 5) ? 255 : $urandom_range(0, 30);
                        queue_byte({4'h0, 4'((back_dist - 1) >> 8)});
                        queue_byte(8'(back_dist - 1));
                        queue_byte(8'(len));
                        len += 18;
                    end
                    produced += len;
                end
            end
            stim_q[code_pos] = code;
        end
        stream_cnt++;
    endfunction

    initial
    begin
        int sz;
        int r;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // -- directed: zero-size stream, then a body covering literal extremes,
        //    longest short reference, longest long reference with overlap,
        //    shortest long reference, overshoot of the size, dropped flag
        push_header(32'd0);
        push_header(32'd300);
        queue_byte(8'hC8);
        queue_byte(8'hFF); queue_byte(8'h00);
        queue_byte(8'hF0); queue_byte(8'h00);
        queue_byte(8'h00); queue_byte(8'h01); queue_byte(8'hFF);
        queue_byte(8'h5A);
        queue_byte(8'h10); queue_byte(8'h00);
        queue_byte(8'h00); queue_byte(8'h03); queue_byte(8'h00);
        stream_cnt += 2;
        flush_stim();

        // sender pauses until every expected result is out
        wait_drained();

        // -- random streams with junk and broken magics in between
        sz = sent_bytes;
        while (sent_bytes - sz < RAND_BYTES)
        begin
            no_gaps = ($urandom_range(0, 99) < 20);
            repeat ($urandom_range(0, 4))
                queue_byte(junk_byte());
            if ($urandom_range(0, 99) < 25)
            begin
                queue_byte(MAGIC_HEAD[23:16]);
                queue_byte(MAGIC_HEAD[15:8]);
                queue_byte(MAGIC_HEAD[7:0]);
                queue_byte(junk_byte());
            end
            r = $urandom_range(0, 99);
            if (r < 8)
                push_stream(32'd0);
            else if (r < 18)
                push_stream($urandom_range(100, 300));
            else
                push_stream($urandom_range(1, 40));
            flush_stim();
        end
        no_gaps = 1'b0;
        wait_drained();

        // -- bad reference: distance 1281 with nothing produced; block halts
        push_header(32'd5);
        queue_byte(8'h00);
        queue_byte(8'h05);
        queue_byte(8'h00);
        stream_cnt++;
        flush_stim();
        wait_drained();
        repeat (40) @(posedge clk);

        $display("covered %0d streams, %0d container bytes, %0d results checked",
                 stream_cnt, sent_bytes, result_count);
        $display("incl. zero size, overshoot, overlapped copies, bad-reference halt");
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+sv
sv/lzd_pkg.sv
sv/lzd_stream_if.sv
sv/lzd_out_if.sv
sv/lzd_parser.sv
sv/lzd_cmd_fifo.sv
sv/lzd_copy_engine.sv
sv/lz_backref_stream_decoder_unit.sv
dv/lz_backref_stream_decoder_unit_chk.sv
dv/lz_backref_stream_decoder_unit_tb.sv
